// ===== design/ecb_pkg.sv =====
package ecb_pkg;

  // Bank geometry and data widths
  localparam int EVENT_TYPES = 16;
  localparam int CLASS_TYPES = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int TIME_WIDTH  = 32;
  localparam int CELL_TOTAL  = EVENT_TYPES * CLASS_TYPES;
  localparam int CELL_W      = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;

  // Field widths
  localparam int OP_W    = 3;
  localparam int EV_W    = 4;
  localparam int CL_W    = 3;
  localparam int EVCFG_W = 5;
  localparam int CLCFG_W = 4;

  // Configuration register indexes and reset values
  localparam logic REG_EVENTS  = 1'b0;
  localparam logic REG_CLASSES = 1'b1;
  localparam logic [EVCFG_W-1:0] EVENTS_RST  = EVCFG_W'(16);
  localparam logic [CLCFG_W-1:0] CLASSES_RST = CLCFG_W'(8);

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_INCREMENT  = 3'd1,
    OP_READ       = 3'd2,
    OP_RESET_ONE  = 3'd3,
    OP_RESET_ALL  = 3'd4,
    OP_PERIOD_ONE = 3'd5,
    OP_PERIOD_ALL = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the request
    logic rd;    // read both cell memories
    logic exec;  // apply the operation and load the result register
  } ecb_cmd_t;

endpackage

// ===== design/ecb_ram.sv =====
module ecb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ecb_ctrl.sv =====
module ecb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ecb_pkg::ecb_cmd_t cmd_o
);

  ecb_pkg::ctrl_state_e state_q, state_d;
  logic                 out_vld_q, out_vld_d;
  logic                 out_free;

  assign out_free = !out_vld_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ecb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ecb_pkg::ST_READ;
        end
      end
      ecb_pkg::ST_READ: begin
        state_d = ecb_pkg::ST_EXEC;
      end
      ecb_pkg::ST_EXEC: begin
        if (out_free) begin
          state_d = ecb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ecb_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ecb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ecb_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      ecb_pkg::ST_EXEC: begin
        cmd_o.exec = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.exec) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ecb_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

  // A request moves through read and execute before the next is taken
  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ecb_pkg::ST_READ)
    else $error("accepted request did not start a read");

  a_read_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ecb_pkg::ST_READ |=> state_q == ecb_pkg::ST_EXEC)
    else $error("read not followed by execute");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (!out_vld_q || out_ready_i))
    else $error("result register overwritten before taken");

  a_exec_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_vld_q)
    else $error("executed request produced no result");

endmodule

// ===== design/ecb_dp.sv =====
module ecb_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ecb_pkg::ecb_cmd_t              cmd_i,
  input  logic [ecb_pkg::OP_W-1:0]       operation_i,
  input  logic [ecb_pkg::EV_W-1:0]       event_type_i,
  input  logic [ecb_pkg::CL_W-1:0]       class_id_i,
  input  logic [ecb_pkg::EVCFG_W-1:0]    events_in_use_i,
  input  logic [ecb_pkg::CLCFG_W-1:0]    classes_in_use_i,
  output logic                           status_o,
  output logic [31:0]                    count_value_o,
  output logic [31:0]                    elapsed_ticks_o
);

  localparam int CW = ecb_pkg::COUNT_WIDTH;
  localparam int TW = ecb_pkg::TIME_WIDTH;
  localparam int AW = ecb_pkg::CELL_W;

  // Captured request
  ecb_pkg::op_e   op_q;
  logic [AW-1:0]  cell_q;
  logic           hit_q;
  logic           in_range;
  logic [AW-1:0]  cell_in;

  // Bank state
  logic [TW-1:0]  time_now_q, time_now_d;
  logic [TW-1:0]  global_q, global_d;
  logic [ecb_pkg::CELL_TOTAL-1:0] cnt_vld_q, cnt_vld_d;
  logic [ecb_pkg::CELL_TOTAL-1:0] tim_vld_q, tim_vld_d;

  // Memory ports
  logic           cnt_we, tim_we;
  logic [CW-1:0]  cnt_wdata, cnt_rdata, cnt_cur;
  logic [TW-1:0]  tim_rdata, tim_cur;

  // Result register
  logic           status_q;
  logic [31:0]    count_q, elapsed_q;
  logic           res_status;
  logic [31:0]    res_count, res_elapsed;

  // Check the indexes against the configured and built limits
  assign in_range = ({1'b0, event_type_i} < events_in_use_i)
                 && (32'(event_type_i) < ecb_pkg::EVENT_TYPES)
                 && ({1'b0, class_id_i} < classes_in_use_i)
                 && (32'(class_id_i) < ecb_pkg::CLASS_TYPES);
  assign cell_in = AW'(32'(event_type_i) * ecb_pkg::CLASS_TYPES + 32'(class_id_i));

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= ecb_pkg::op_e'(operation_i);
      cell_q <= in_range ? cell_in : '0;
      hit_q  <= in_range;
    end
  end

  ecb_ram #(.WIDTH(CW), .DEPTH(ecb_pkg::CELL_TOTAL)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cell_q),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (cell_q),
    .rdata_o (cnt_rdata)
  );

  ecb_ram #(.WIDTH(TW), .DEPTH(ecb_pkg::CELL_TOTAL)) u_tim_ram (
    .clk_i   (clk_i),
    .we_i    (tim_we),
    .waddr_i (cell_q),
    .wdata_i (time_now_q),
    .re_i    (cmd_i.rd),
    .raddr_i (cell_q),
    .rdata_o (tim_rdata)
  );

  // Cells not written since the last bank clear read as cleared
  assign cnt_cur = cnt_vld_q[cell_q] ? cnt_rdata : '0;
  assign tim_cur = tim_vld_q[cell_q] ? tim_rdata : global_q;

  // Apply the operation
  always_comb begin
    time_now_d  = time_now_q;
    global_d    = global_q;
    cnt_vld_d   = cnt_vld_q;
    tim_vld_d   = tim_vld_q;
    cnt_we      = 1'b0;
    tim_we      = 1'b0;
    cnt_wdata   = '0;
    res_status  = 1'b0;
    res_count   = '0;
    res_elapsed = '0;
    if (cmd_i.exec) begin
      case (op_q)
        ecb_pkg::OP_TICK: begin
          time_now_d = time_now_q + TW'(1);
        end
        ecb_pkg::OP_INCREMENT: begin
          res_status = !hit_q;
          if (hit_q) begin
            cnt_we            = 1'b1;
            cnt_wdata         = cnt_cur + CW'(1);
            cnt_vld_d[cell_q] = 1'b1;
          end
        end
        ecb_pkg::OP_READ: begin
          res_status = !hit_q;
          if (hit_q) begin
            res_count = 32'(cnt_cur);
          end
        end
        ecb_pkg::OP_RESET_ONE: begin
          res_status = !hit_q;
          if (hit_q) begin
            cnt_we            = 1'b1;
            tim_we            = 1'b1;
            cnt_vld_d[cell_q] = 1'b1;
            tim_vld_d[cell_q] = 1'b1;
          end
        end
        ecb_pkg::OP_RESET_ALL: begin
          global_d  = time_now_q;
          cnt_vld_d = '0;
          tim_vld_d = '0;
        end
        ecb_pkg::OP_PERIOD_ONE: begin
          res_status = !hit_q;
          if (hit_q) begin
            res_elapsed = 32'(time_now_q - tim_cur);
          end
        end
        ecb_pkg::OP_PERIOD_ALL: begin
          res_elapsed = 32'(time_now_q - global_q);
        end
        default: begin
          res_status = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_now_q <= '0;
      global_q   <= '0;
      cnt_vld_q  <= '0;
      tim_vld_q  <= '0;
    end else begin
      time_now_q <= time_now_d;
      global_q   <= global_d;
      cnt_vld_q  <= cnt_vld_d;
      tim_vld_q  <= tim_vld_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q  <= res_status;
      count_q   <= res_count;
      elapsed_q <= res_elapsed;
    end
  end

  assign status_o        = status_q;
  assign count_value_o   = count_q;
  assign elapsed_ticks_o = elapsed_q;

endmodule

// ===== design/event_counter_bank_unit.sv =====
// Channel   Handshake                    Payload
// request   in_valid_i / in_ready_o      operation_i, event_type_i, class_id_i
// result    out_valid_o / out_ready_i    status_o, count_value_o, elapsed_ticks_o
// config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// Each request passes through three steps: capture, memory read, execute.
// The registered read of the cell memories calls for the memory read step.
// A waiting result holds the execute step until the result register frees.
// Reset all drops the per-cell valid bits; there is no clearing pass.
// Reset (rst_ni low) drops the valid bits: counts and times read as cleared.
module event_counter_bank_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  event_type_i,
  input  logic [2:0]  class_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [31:0] count_value_o,
  output logic [31:0] elapsed_ticks_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ecb_pkg::ecb_cmd_t                 cmd;
  logic [ecb_pkg::EVCFG_W-1:0]       events_q;
  logic [ecb_pkg::CLCFG_W-1:0]       classes_q;
  logic                              wr_en;

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      events_q  <= ecb_pkg::EVENTS_RST;
      classes_q <= ecb_pkg::CLASSES_RST;
    end else if (wr_en) begin
      if (paddr[2] == ecb_pkg::REG_EVENTS) begin
        events_q <= pwdata[ecb_pkg::EVCFG_W-1:0];
      end else begin
        classes_q <= pwdata[ecb_pkg::CLCFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == ecb_pkg::REG_CLASSES) ? 32'(classes_q) : 32'(events_q);

  ecb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ecb_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .operation_i      (operation_i),
    .event_type_i     (event_type_i),
    .class_id_i       (class_id_i),
    .events_in_use_i  (events_q),
    .classes_in_use_i (classes_q),
    .status_o         (status_o),
    .count_value_o    (count_value_o),
    .elapsed_ticks_o  (elapsed_ticks_o)
  );

endmodule

// ===== bench/event_counter_bank_unit_tb.sv =====
`timescale 1ns / 1ps

module event_counter_bank_unit_tb;

  // Operation code the block leaves unused
  localparam logic [ecb_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [ecb_pkg::OP_W-1:0] op;
    logic [ecb_pkg::EV_W-1:0] ev;
    logic [ecb_pkg::CL_W-1:0] cl;
  } bank_req_t;

  typedef struct packed {
    logic                            status;
    logic [ecb_pkg::COUNT_WIDTH-1:0] count;
    logic [ecb_pkg::TIME_WIDTH-1:0]  elapsed;
  } bank_ans_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] operation_i = '0;
  logic [3:0] event_type_i = '0;
  logic [2:0] class_id_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic [31:0] count_value_o;
  logic [31:0] elapsed_ticks_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Predicted bank contents and limits
  logic [ecb_pkg::COUNT_WIDTH-1:0] cell_count_copy [ecb_pkg::CELL_TOTAL];
  logic [ecb_pkg::TIME_WIDTH-1:0]  cell_stamp_copy [ecb_pkg::CELL_TOTAL];
  logic [ecb_pkg::TIME_WIDTH-1:0]  global_stamp_copy;
  logic [ecb_pkg::TIME_WIDTH-1:0]  ticks_now;
  logic [ecb_pkg::EVCFG_W-1:0]     events_limit;
  logic [ecb_pkg::CLCFG_W-1:0]     classes_limit;

  bank_req_t request_q[$];
  bank_ans_t answer_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit req_taken = 1'b0;
  int cycle_count = 0;
  int mismatch_count = 0;

  event_counter_bank_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // Apply one request to the copy of the bank and return its answer
  function automatic bank_ans_t predict_bank_answer(bank_req_t r);
    bank_ans_t a;
    logic in_range;
    int cell_idx;
    a = '0;
    in_range = (r.ev < events_limit) && (int'(r.ev) < ecb_pkg::EVENT_TYPES) &&
               (r.cl < classes_limit) && (int'(r.cl) < ecb_pkg::CLASS_TYPES);
    cell_idx = int'(r.ev) * ecb_pkg::CLASS_TYPES + int'(r.cl);
    case (r.op)
      ecb_pkg::OP_TICK: ticks_now = ticks_now + 1'b1;
      ecb_pkg::OP_INCREMENT, ecb_pkg::OP_READ, ecb_pkg::OP_RESET_ONE,
      ecb_pkg::OP_PERIOD_ONE: begin
        if (!in_range || cell_idx >= ecb_pkg::CELL_TOTAL) begin
          a.status = 1'b1;
        end else if (r.op == ecb_pkg::OP_INCREMENT) begin
          cell_count_copy[cell_idx] = cell_count_copy[cell_idx] + 1'b1;
        end else if (r.op == ecb_pkg::OP_READ) begin
          a.count = cell_count_copy[cell_idx];
        end else if (r.op == ecb_pkg::OP_RESET_ONE) begin
          cell_count_copy[cell_idx] = '0;
          cell_stamp_copy[cell_idx] = ticks_now;
        end else begin
          a.elapsed = ticks_now - cell_stamp_copy[cell_idx];
        end
      end
      ecb_pkg::OP_RESET_ALL: begin
        global_stamp_copy = ticks_now;
        for (int i = 0; i < ecb_pkg::CELL_TOTAL; i++) begin
          cell_count_copy[i] = '0;
          cell_stamp_copy[i] = ticks_now;
        end
      end
      ecb_pkg::OP_PERIOD_ALL: a.elapsed = ticks_now - global_stamp_copy;
      default: ;
    endcase
    return a;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Drive requests and result back-pressure on the falling edge
  always @(negedge clk_i) begin
    bank_req_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_q.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= nxt.op;
          event_type_i <= nxt.ev;
          class_id_i <= nxt.cl;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    bank_req_t req;
    bank_ans_t got;
    bank_ans_t want;
    req_taken = rst_ni && in_valid_i && in_ready_o;
    if (req_taken) begin
      req.op = operation_i;
      req.ev = event_type_i;
      req.cl = class_id_i;
      answer_q.push_back(predict_bank_answer(req));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = status_o;
      got.count = count_value_o;
      got.elapsed = elapsed_ticks_o;
      if (answer_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected: status %0d count %0d elapsed %0d",
                                got.status, got.count, got.elapsed));
      end else begin
        want = answer_q.pop_front();
        if (got.status !== want.status || got.count !== want.count ||
            got.elapsed !== want.elapsed) begin
          flag_mismatch($sformatf({"expected status %0d count %0d elapsed %0d, ",
                                   "got status %0d count %0d elapsed %0d"},
                                  want.status, want.count, want.elapsed,
                                  got.status, got.count, got.elapsed));
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL event_counter_bank_unit");
      $finish;
    end
  end

  task automatic queue_request(logic [ecb_pkg::OP_W-1:0] op, logic [ecb_pkg::EV_W-1:0] ev,
                               logic [ecb_pkg::CL_W-1:0] cl);
    bank_req_t r;
    r.op = op;
    r.ev = ev;
    r.cl = cl;
    request_q.push_back(r);
  endtask

  task automatic queue_random(int n);
    int pick;
    logic [ecb_pkg::OP_W-1:0] op;
    logic [ecb_pkg::EV_W-1:0] ev;
    logic [ecb_pkg::CL_W-1:0] cl;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 18) op = ecb_pkg::OP_TICK;
      else if (pick < 48) op = ecb_pkg::OP_INCREMENT;
      else if (pick < 64) op = ecb_pkg::OP_READ;
      else if (pick < 72) op = ecb_pkg::OP_RESET_ONE;
      else if (pick < 74) op = ecb_pkg::OP_RESET_ALL;
      else if (pick < 86) op = ecb_pkg::OP_PERIOD_ONE;
      else if (pick < 96) op = ecb_pkg::OP_PERIOD_ALL;
      else op = OP_UNUSED;
      // aim most traffic at a few hot cells so reads see real counts
      if ($urandom_range(99) < 60) begin
        ev = ecb_pkg::EV_W'($urandom_range(3));
        cl = ecb_pkg::CL_W'($urandom_range(1));
      end else begin
        ev = ecb_pkg::EV_W'($urandom_range(15));
        cl = ecb_pkg::CL_W'($urandom_range(7));
      end
      queue_request(op, ev, cl);
    end
  endtask

  task automatic write_reg(logic idx, int value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() & ~32'hFF) | (value & 32'hFF);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == ecb_pkg::REG_EVENTS) events_limit = ecb_pkg::EVCFG_W'(value);
    else classes_limit = ecb_pkg::CLCFG_W'(value);
  endtask

  task automatic configure(int ev_lim, int cl_lim, idle_mode_e mode);
    write_reg(ecb_pkg::REG_EVENTS, ev_lim);
    write_reg(ecb_pkg::REG_CLASSES, cl_lim);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 59;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 59;
      end
      IDLE_BOTH: begin
        send_idle_pct = 27;
        recv_stall_pct = 27;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Hold until every request is sent and every result is back
  task automatic drain();
    while (request_q.size() != 0 || in_valid_i || answer_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    for (int i = 0; i < ecb_pkg::CELL_TOTAL; i++) begin
      cell_count_copy[i] = '0;
      cell_stamp_copy[i] = '0;
    end
    global_stamp_copy = '0;
    ticks_now = '0;
    events_limit = ecb_pkg::EVENTS_RST;
    classes_limit = ecb_pkg::CLASSES_RST;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits: corner cells, clears and elapsed times
    queue_request(ecb_pkg::OP_READ, 4'd0, 3'd0);
    queue_request(ecb_pkg::OP_PERIOD_ALL, 4'd0, 3'd0);
    queue_request(ecb_pkg::OP_TICK, 4'd15, 3'd7);
    queue_request(ecb_pkg::OP_INCREMENT, 4'd0, 3'd0);
    queue_request(ecb_pkg::OP_INCREMENT, 4'd15, 3'd7);
    queue_request(ecb_pkg::OP_INCREMENT, 4'd15, 3'd7);
    queue_request(ecb_pkg::OP_READ, 4'd15, 3'd7);
    queue_request(ecb_pkg::OP_PERIOD_ONE, 4'd15, 3'd7);
    queue_request(ecb_pkg::OP_TICK, 4'd0, 3'd0);
    queue_request(ecb_pkg::OP_RESET_ONE, 4'd15, 3'd7);
    queue_request(ecb_pkg::OP_READ, 4'd15, 3'd7);
    queue_request(ecb_pkg::OP_PERIOD_ONE, 4'd15, 3'd7);
    queue_request(ecb_pkg::OP_PERIOD_ALL, 4'd0, 3'd0);
    queue_request(ecb_pkg::OP_RESET_ALL, 4'd15, 3'd7);
    queue_request(ecb_pkg::OP_READ, 4'd0, 3'd0);
    queue_request(ecb_pkg::OP_PERIOD_ONE, 4'd0, 3'd0);
    queue_request(OP_UNUSED, 4'd15, 3'd7);
    queue_random(180);
    drain();

    // Limits beyond the bank
    configure(31, 15, IDLE_SENDER);
    queue_random(180);
    drain();

    // Single cell in use: out-of-range indices on each side
    configure(1, 1, IDLE_RECEIVER);
    queue_request(ecb_pkg::OP_INCREMENT, 4'd0, 3'd0);
    queue_request(ecb_pkg::OP_INCREMENT, 4'd1, 3'd0);
    queue_request(ecb_pkg::OP_INCREMENT, 4'd0, 3'd1);
    queue_request(ecb_pkg::OP_READ, 4'd15, 3'd7);
    queue_request(ecb_pkg::OP_RESET_ONE, 4'd0, 3'd1);
    queue_request(ecb_pkg::OP_PERIOD_ONE, 4'd1, 3'd0);
    queue_request(ecb_pkg::OP_READ, 4'd0, 3'd0);
    queue_request(ecb_pkg::OP_PERIOD_ALL, 4'd15, 3'd7);
    queue_random(140);
    drain();

    // Zero limits flag every addressed cell
    configure(0, 0, IDLE_BOTH);
    queue_random(50);
    drain();

    configure(16, 0, IDLE_SENDER);
    queue_random(50);
    drain();

    configure(0, 8, IDLE_RECEIVER);
    queue_random(60);
    drain();

    configure(11, 5, IDLE_BOTH);
    queue_random(200);
    drain();

    configure(16, 8, IDLE_NONE);
    queue_random(230);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && answer_q.size() == 0) begin
      $display("PASS event_counter_bank_unit");
    end else begin
      $display("FAIL event_counter_bank_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ecb_pkg.sv
design/ecb_ram.sv
design/ecb_ctrl.sv
design/ecb_dp.sv
design/event_counter_bank_unit.sv
bench/event_counter_bank_unit_tb.sv
